// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the line splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/at_rls_pkg.sv =====
// Shared types and constants of the AT response line splitter.
package at_rls_pkg;

    typedef logic [7:0] t_char;

    localparam t_char CH_CR = 8'h0D;
    localparam t_char CH_LF = 8'h0A;

    localparam int OK_LEN  = 2;
    localparam int ERR_LEN = 10;

    // "OK" and "+CME ERROR"
    localparam t_char OK_TEXT [OK_LEN] = '{8'h4F, 8'h4B};
    localparam t_char ERR_TEXT [ERR_LEN] = '{8'h2B, 8'h43, 8'h4D, 8'h45, 8'h20,
                                             8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

    localparam int IDX_W = 5;
    localparam int LEN_W = 8;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    typedef struct packed {
        logic [IDX_W-1:0] line_index;
        logic [LEN_W-1:0] line_length;
        logic             starts_ok;
        logic             starts_error;
        logic             any_ok;
        logic             any_error;
        logic             count_overflow;
        logic             final_result;
    } t_result;

endpackage

// ===== rtl/at_response_line_splitter.sv =====
// AT response line splitter: takes one received byte a cycle and reports each closed line
// (index, byte length, OK / +CME ERROR prefix, sticky flags, overflow). A byte is registered,
// decoded from the input register and its words enter a four-word result queue, whose head
// is the output. The input takes a byte every cycle while the queue can take two more words;
// an LF that ends a buffer may give two words, which leave one a cycle while the receiver is
// ready, so the result queue drain can hold the input.
module at_response_line_splitter #(
    parameter int MAX_LINE  = 255,
    parameter int MAX_LINES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_in_buffer,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_line_index,
    output logic [7:0] o_line_length,
    output logic       o_starts_ok,
    output logic       o_starts_error,
    output logic       o_any_ok,
    output logic       o_any_error,
    output logic       o_count_overflow,
    output logic       o_final_result
);
    import at_rls_pkg::*;
    `include "assert_macros.svh"

    logic       r_in_valid;
    logic       r_cmd;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_fire, w_room2, w_pop;
    logic [1:0] w_num;
    t_result    w_res0, w_res1, w_head;

    assign w_pop   = o_valid && i_ready;
    assign w_fire  = r_in_valid && w_room2;
    assign o_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd  <= i_cmd;
            r_byte <= i_byte_value;
            r_last <= i_last_in_buffer;
        end
    end

    at_rls_core #(
        .MAX_LINE  (MAX_LINE),
        .MAX_LINES (MAX_LINES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_cmd            (r_cmd),
        .i_byte_value     (r_byte),
        .i_last_in_buffer (r_last),
        .o_res0           (w_res0),
        .o_res1           (w_res1),
        .o_num            (w_num)
    );

    at_rls_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (w_fire ? w_num : 2'd0),
        .i_push0    (w_res0),
        .i_push1    (w_res1),
        .i_pop      (w_pop),
        .o_valid    (o_valid),
        .o_head     (w_head),
        .o_room2    (w_room2)
    );

    assign o_line_index     = w_head.line_index;
    assign o_line_length    = w_head.line_length;
    assign o_starts_ok      = w_head.starts_ok;
    assign o_starts_error   = w_head.starts_error;
    assign o_any_ok         = w_head.any_ok;
    assign o_any_error      = w_head.any_error;
    assign o_count_overflow = w_head.count_overflow;
    assign o_final_result   = w_head.final_result;

    // a held byte must stay in the input register until decoded
    `ASSERT_NEXT(a_top_hold_byte, i_clk, i_rst_n, r_in_valid && !w_fire, r_in_valid,
        "held input word lost")

endmodule

// ===== rtl/at_rls_result_fifo.sv =====
// Result queue: takes up to two result words a cycle, hands out one.
module at_rls_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_num,
    input  at_rls_pkg::t_result i_push0,
    input  at_rls_pkg::t_result i_push1,
    input  logic               i_pop,
    output logic               o_valid,
    output at_rls_pkg::t_result o_head,
    output logic               o_room2
);
    import at_rls_pkg::*;
    `include "assert_macros.svh"

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;
    logic [RES_PTR_W-1:0] w_wr_ptr1;

    assign o_valid   = (r_cnt != '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign o_room2   = ((r_cnt - RES_CNT_W'(i_pop)) <= RES_CNT_W'(2));
    assign w_wr_ptr1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + RES_PTR_W'(i_push_num);
        n_rd_ptr = r_rd_ptr + RES_PTR_W'(i_pop);
        n_cnt    = r_cnt + RES_CNT_W'(i_push_num) - RES_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_num == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push1;
        end
    end

    `ASSERT_RST(a_fifo_no_overrun, i_clk, i_rst_n,
        (r_cnt + RES_CNT_W'(i_push_num) - RES_CNT_W'(i_pop)) <= RES_CNT_W'(RES_DEPTH),
        "result queue overrun")
    `ASSERT_RST(a_fifo_pop_when_valid, i_clk, i_rst_n, i_pop |-> o_valid,
        "result queue popped while empty")

endmodule

// ===== rtl/at_rls_core.sv =====
// Line state and per-byte decision: produces up to two closed-line words per byte.
module at_rls_core #(
    parameter int MAX_LINE  = 255,
    parameter int MAX_LINES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_cmd,
    input  logic [7:0]          i_byte_value,
    input  logic                i_last_in_buffer,
    output at_rls_pkg::t_result o_res0,
    output at_rls_pkg::t_result o_res1,
    output logic [1:0]          o_num
);
    import at_rls_pkg::*;
    `include "assert_macros.svh"

    localparam int LW = $clog2(MAX_LINE + 2);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int EW = (LW > LEN_W) ? LW : LEN_W;
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    logic          r_framed, n_framed;
    logic          r_unframed, n_unframed;
    logic          r_drop, n_drop;
    logic          r_pok, n_pok;
    logic          r_perr, n_perr;
    logic [LW-1:0] r_len, n_len;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_sok, n_sok;
    logic          r_serr, n_serr;

    logic          w_handle, w_is_lf, w_close1, w_close2;
    logic          w_framed1, w_unframed1, w_drop1, w_pok1, w_perr1, w_sok1, w_serr1;
    logic [LW-1:0] w_len1, w_len_inc;
    logic [CW-1:0] w_cnt1;
    t_result       w_r0, w_r1;

    function automatic t_result close_res(input logic [LW-1:0] len, input logic pok,
                                          input logic perr, input logic [CW-1:0] cnt,
                                          input logic sok, input logic serr);
        t_result       r;
        logic [EW-1:0] le;
        logic [IW-1:0] ie;
        logic          over;
        logic          is_ok;
        logic          is_err;
        le     = EW'(len);
        ie     = IW'(cnt);
        over   = (cnt >= CW'(MAX_LINES));
        is_ok  = pok && (len >= LW'(OK_LEN));
        is_err = perr && (len >= LW'(ERR_LEN));
        r.line_index     = ie[IDX_W-1:0];
        r.line_length    = (le > EW'(255)) ? 8'hFF : le[LEN_W-1:0];
        r.starts_ok      = is_ok;
        r.starts_error   = is_err;
        r.any_ok         = sok | (is_ok & ~over);
        r.any_error      = serr | (is_err & ~over);
        r.count_overflow = over;
        r.final_result   = 1'b0;
        return r;
    endfunction

    always_comb begin
        w_handle  = !i_cmd && !r_drop && (i_byte_value != CH_CR);
        w_is_lf   = (i_byte_value == CH_LF);
        w_close1  = w_handle && w_is_lf && (r_framed || r_unframed);
        w_len_inc = r_len + 1'b1;
        w_r0      = close_res(r_len, r_pok, r_perr, r_cnt, r_sok, r_serr);

        w_framed1   = r_framed;
        w_unframed1 = r_unframed;
        w_drop1     = r_drop;
        w_len1      = r_len;
        w_pok1      = r_pok;
        w_perr1     = r_perr;
        w_cnt1      = r_cnt;
        w_sok1      = r_sok;
        w_serr1     = r_serr;

        if (i_cmd) begin
            w_cnt1  = '0;
            w_sok1  = 1'b0;
            w_serr1 = 1'b0;
        end else if (w_handle) begin
            if (w_is_lf) begin
                // LF after an unframed line opens a framed one
                w_unframed1 = 1'b0;
                w_framed1   = r_unframed ? 1'b1 : !r_framed;
                if (w_close1) begin
                    if (!w_r0.count_overflow) begin
                        w_cnt1 = r_cnt + 1'b1;
                    end
                    w_sok1  = w_r0.any_ok;
                    w_serr1 = w_r0.any_error;
                    w_len1  = '0;
                    w_pok1  = 1'b1;
                    w_perr1 = 1'b1;
                end
            end else begin
                if (!r_framed) begin
                    w_unframed1 = 1'b1;
                end
                if ((r_len < LW'(OK_LEN)) && (OK_TEXT[r_len[0]] != i_byte_value)) begin
                    w_pok1 = 1'b0;
                end
                if ((r_len < LW'(ERR_LEN)) && (ERR_TEXT[r_len[3:0]] != i_byte_value)) begin
                    w_perr1 = 1'b0;
                end
                w_len1  = w_len_inc;
                w_drop1 = (w_len_inc > LW'(MAX_LINE));
            end
        end

        w_close2 = !i_cmd && i_last_in_buffer && (w_framed1 || w_unframed1);
        w_r1     = close_res(w_len1, w_pok1, w_perr1, w_cnt1, w_sok1, w_serr1);
    end

    // next state
    always_comb begin
        n_framed   = w_framed1;
        n_unframed = w_unframed1;
        n_drop     = w_drop1;
        n_len      = w_len1;
        n_pok      = w_pok1;
        n_perr     = w_perr1;
        n_cnt      = w_cnt1;
        n_sok      = w_sok1;
        n_serr     = w_serr1;
        if (w_close2) begin
            if (!w_r1.count_overflow) begin
                n_cnt = w_cnt1 + 1'b1;
            end
            n_sok  = w_r1.any_ok;
            n_serr = w_r1.any_error;
        end
        if (!i_cmd && i_last_in_buffer) begin
            n_framed   = 1'b0;
            n_unframed = 1'b0;
            n_drop     = 1'b0;
            n_len      = '0;
            n_pok      = 1'b1;
            n_perr     = 1'b1;
        end
    end

    // result words in order, last one marked final
    always_comb begin
        o_res0 = w_r0;
        o_res1 = w_r1;
        o_num  = 2'd0;
        if (w_close1 && w_close2) begin
            o_res1.final_result = 1'b1;
            o_num = 2'd2;
        end else if (w_close1) begin
            o_res0.final_result = 1'b1;
            o_num = 2'd1;
        end else if (w_close2) begin
            o_res0 = w_r1;
            o_res0.final_result = 1'b1;
            o_num = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_framed   <= 1'b0;
            r_unframed <= 1'b0;
            r_drop     <= 1'b0;
            r_len      <= '0;
            r_pok      <= 1'b1;
            r_perr     <= 1'b1;
            r_cnt      <= '0;
            r_sok      <= 1'b0;
            r_serr     <= 1'b0;
        end else if (i_fire) begin
            r_framed   <= n_framed;
            r_unframed <= n_unframed;
            r_drop     <= n_drop;
            r_len      <= n_len;
            r_pok      <= n_pok;
            r_perr     <= n_perr;
            r_cnt      <= n_cnt;
            r_sok      <= n_sok;
            r_serr     <= n_serr;
        end
    end

    `ASSERT_RST(a_core_count_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_LINES),
        "line count beyond store size")
    `ASSERT_RST(a_core_drop_len, i_clk, i_rst_n, r_drop |-> (r_len == LW'(MAX_LINE + 1)),
        "dropping without an over-long line")
    `ASSERT_RST(a_core_one_line_open, i_clk, i_rst_n, !(r_framed && r_unframed),
        "framed and unframed line open together")

endmodule

// ===== bench/at_response_line_splitter_tb.sv =====
// Self-checking testbench of the AT response line splitter: random byte streams, line predictor.
`timescale 1ns / 1ps

module at_response_line_splitter_tb;
    import at_rls_pkg::*;

    localparam int MAX_LINE  = 255;
    localparam int MAX_LINES = 16;

    localparam int N_WORDS     = 1325;
    localparam int GAP_PCT     = 14;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT    = 800;
    localparam int STEADY_LO   = 500;
    localparam int STEADY_HI   = 800;

    typedef struct packed {
        logic  hold;
        logic  cmd;
        t_char byte_v;
        logic  last;
    } t_rx_word;

    typedef enum int {TXT_OK, TXT_ERR, TXT_NEAR, TXT_SHORT, TXT_RANDOM} t_text_kind;

    logic       i_clk;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic       i_cmd            = 1'b0;
    logic [7:0] i_byte_value     = 8'h00;
    logic       i_last_in_buffer = 1'b0;
    logic       i_ready          = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [4:0] o_line_index;
    logic [7:0] o_line_length;
    logic       o_starts_ok;
    logic       o_starts_error;
    logic       o_any_ok;
    logic       o_any_error;
    logic       o_count_overflow;
    logic       o_final_result;

    at_response_line_splitter #(
        .MAX_LINE  (MAX_LINE),
        .MAX_LINES (MAX_LINES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_byte_value     (i_byte_value),
        .i_last_in_buffer (i_last_in_buffer),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_line_index     (o_line_index),
        .o_line_length    (o_line_length),
        .o_starts_ok      (o_starts_ok),
        .o_starts_error   (o_starts_error),
        .o_any_ok         (o_any_ok),
        .o_any_error      (o_any_error),
        .o_count_overflow (o_count_overflow),
        .o_final_result   (o_final_result)
    );

    t_rx_word words_pending [$];
    t_result  lines_due [$];
    t_char    line_bytes [$];
    t_rx_word cur_word;
    t_rx_word head_word;
    t_result  got_line;
    t_result  want_line;
    int       words_sent   = 0;
    int       mismatches   = 0;
    int       hold_left    = 0;
    logic     hold_done    = 1'b0;
    logic     drain_marked = 1'b0;
    logic     steady;

    // Predictor state
    logic       in_framed   = 1'b0;
    logic       in_unframed = 1'b0;
    logic [8:0] line_len    = '0;
    logic       skip_rest   = 1'b0;
    logic       may_be_ok   = 1'b1;
    logic       may_be_err  = 1'b1;
    logic [4:0] lines_seen  = '0;
    logic       seen_ok     = 1'b0;
    logic       seen_err    = 1'b0;

    assign steady = (words_sent >= STEADY_LO) && (words_sent < STEADY_HI);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void start_line();
        line_len   = '0;
        may_be_ok  = 1'b1;
        may_be_err = 1'b1;
    endfunction

    function automatic string line_text(input t_result r);
        return $sformatf("idx=%0d len=%0d ok=%b err=%b aok=%b aerr=%b ovf=%b fin=%b",
                         r.line_index, r.line_length, r.starts_ok, r.starts_error,
                         r.any_ok, r.any_error, r.count_overflow, r.final_result);
    endfunction

    function automatic t_result close_line();
        t_result r;
        logic    hit_ok;
        logic    hit_err;
        logic    full;
        hit_ok  = may_be_ok && (line_len >= OK_LEN);
        hit_err = may_be_err && (line_len >= ERR_LEN);
        full    = (lines_seen >= MAX_LINES);
        r.line_index = lines_seen;
        if (!full) begin
            lines_seen = lines_seen + 1'b1;
            seen_ok    = seen_ok | hit_ok;
            seen_err   = seen_err | hit_err;
        end
        r.line_length    = (line_len > 9'd255) ? 8'd255 : line_len[7:0];
        r.starts_ok      = hit_ok;
        r.starts_error   = hit_err;
        r.any_ok         = seen_ok;
        r.any_error      = seen_err;
        r.count_overflow = full;
        r.final_result   = 1'b0;
        start_line();
        return r;
    endfunction

    // Work out the line reports caused by one accepted word and queue them.
    task automatic split_byte(input t_rx_word w);
        t_result outs [2];
        int      k;
        k = 0;
        if (w.cmd) begin
            lines_seen = '0;
            seen_ok    = 1'b0;
            seen_err   = 1'b0;
        end else begin
            if (!skip_rest && w.byte_v != CH_CR) begin
                if (w.byte_v == CH_LF) begin
                    if (in_unframed) begin
                        outs[k] = close_line();
                        k = k + 1;
                        in_unframed = 1'b0;
                        in_framed   = 1'b1;
                    end else if (!in_framed) begin
                        in_framed = 1'b1;
                    end else begin
                        outs[k] = close_line();
                        k = k + 1;
                        in_framed = 1'b0;
                    end
                end else begin
                    if (!in_framed) in_unframed = 1'b1;
                    if (line_len < OK_LEN && OK_TEXT[line_len[0]] != w.byte_v)
                        may_be_ok = 1'b0;
                    if (line_len < ERR_LEN && ERR_TEXT[line_len[3:0]] != w.byte_v)
                        may_be_err = 1'b0;
                    line_len = line_len + 1'b1;
                    if (line_len > MAX_LINE) skip_rest = 1'b1;
                end
            end
            if (w.last) begin
                if (in_framed || in_unframed) begin
                    outs[k] = close_line();
                    k = k + 1;
                end
                in_framed   = 1'b0;
                in_unframed = 1'b0;
                skip_rest   = 1'b0;
                start_line();
            end
            if (k > 0) outs[k-1].final_result = 1'b1;
            for (int i = 0; i < k; i++) lines_due.push_back(outs[i]);
        end
    endtask

    // Sender: present pending words, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                split_byte(cur_word);
                words_sent <= words_sent + 1;
            end
            if (!i_valid || o_ready) begin
                if (words_pending.size() > 0) head_word = words_pending[0];
                if (words_pending.size() > 0 && !(head_word.hold && lines_due.size() != 0)
                    && !(!steady && $urandom_range(0, 99) < GAP_PCT)) begin
                    head_word = words_pending.pop_front();
                    cur_word         <= head_word;
                    i_valid          <= 1'b1;
                    i_cmd            <= head_word.cmd;
                    i_byte_value     <= head_word.byte_v;
                    i_last_in_buffer <= head_word.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each line report against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got_line = {o_line_index, o_line_length, o_starts_ok, o_starts_error,
                            o_any_ok, o_any_error, o_count_overflow, o_final_result};
                if (lines_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected line report: %s", line_text(got_line));
                end else begin
                    want_line = lines_due.pop_front();
                    if (got_line !== want_line) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("line report mismatch at %0t", $realtime);
                            $display("  expected %s", line_text(want_line));
                            $display("  actual   %s", line_text(got_line));
                        end
                    end
                end
            end
            // hold off for a long stretch once, so the result queue fills and input stalls
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (!hold_done && words_sent >= HOLD_AT) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= GAP_PCT);
            end
        end
    end

    function automatic t_char text_byte();
        t_char b;
        do begin
            b = t_char'($urandom_range(0, 255));
        end while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic push_word(input logic cmd, input t_char b, input logic last);
        t_rx_word w;
        w.cmd    = cmd;
        w.byte_v = b;
        w.last   = last;
        w.hold   = 1'b0;
        // make the sender wait for every report once
        if (!drain_marked && words_pending.size() >= DRAIN_AT) begin
            w.hold       = 1'b1;
            drain_marked = 1'b1;
        end
        words_pending.push_back(w);
    endtask

    task automatic flush_buffer(input logic with_last);
        if (with_last && line_bytes.size() == 0) line_bytes.push_back(CH_CR);
        for (int i = 0; i < line_bytes.size(); i++)
            push_word(1'b0, line_bytes[i], with_last && (i == line_bytes.size() - 1));
        line_bytes.delete();
    endtask

    task automatic add_text(input t_char s [$]);
        foreach (s[i]) line_bytes.push_back(s[i]);
    endtask

    task automatic add_line(input logic framed);
        t_text_kind kind;
        int         n;
        t_char      b;
        kind = t_text_kind'($urandom_range(0, 4));
        if (framed) begin
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
        end
        case (kind)
            TXT_OK: begin
                foreach (OK_TEXT[i]) line_bytes.push_back(OK_TEXT[i]);
                repeat ($urandom_range(0, 4)) line_bytes.push_back(text_byte());
            end
            TXT_ERR: begin
                foreach (ERR_TEXT[i]) line_bytes.push_back(ERR_TEXT[i]);
                repeat ($urandom_range(0, 4)) line_bytes.push_back(text_byte());
            end
            TXT_NEAR: begin
                // match part of the error prefix, then break off
                n = $urandom_range(1, ERR_LEN - 1);
                for (int i = 0; i < n; i++) line_bytes.push_back(ERR_TEXT[i]);
                do b = text_byte(); while (b == ERR_TEXT[n]);
                line_bytes.push_back(b);
            end
            TXT_SHORT: begin
                line_bytes.push_back(OK_TEXT[0]);
                if ($urandom_range(0, 1)) begin
                    do b = text_byte(); while (b == OK_TEXT[1]);
                    line_bytes.push_back(b);
                end
            end
            default: begin
                repeat ($urandom_range(0, 8)) line_bytes.push_back(text_byte());
            end
        endcase
        n = $urandom_range(0, 9);
        if (n < 7) begin
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
        end else if (n < 9) begin
            line_bytes.push_back(CH_LF);
        end
    endtask

    task automatic add_long_line(input int len);
        repeat (len) line_bytes.push_back(text_byte());
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endtask

    initial begin
        int pick;
        int n;
        int sel;
        int nbuf;

        // directed words
        push_word(1'b1, 8'hFF, 1'b1);
        add_text({CH_CR, CH_LF, OK_TEXT[0], OK_TEXT[1], CH_CR, CH_LF});
        flush_buffer(1'b1);
        foreach (ERR_TEXT[i]) line_bytes.push_back(ERR_TEXT[i]);
        flush_buffer(1'b1);
        line_bytes.push_back(OK_TEXT[0]);
        flush_buffer(1'b1);
        // unframed line closed by an LF that ends the buffer: two reports
        add_text({8'h00, CH_LF});
        flush_buffer(1'b1);
        push_word(1'b0, 8'hFF, 1'b1);
        push_word(1'b0, CH_LF, 1'b1);
        // clear while a line is in progress
        push_word(1'b0, OK_TEXT[0], 1'b0);
        push_word(1'b1, 8'h00, 1'b0);
        push_word(1'b0, OK_TEXT[1], 1'b1);

        nbuf = 0;
        while (words_pending.size() < N_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                push_word(1'b1, t_char'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (pick < 16) begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    sel = $urandom_range(0, 3);
                    line_bytes.push_back(sel == 0 ? CH_CR :
                                         sel == 1 ? CH_LF : t_char'($urandom_range(0, 255)));
                end
                flush_buffer(1'b1);
            end else begin
                nbuf = nbuf + 1;
                if (nbuf == 12) add_long_line(MAX_LINE);
                else if (nbuf == 45) add_long_line(MAX_LINE + 4);
                n = $urandom_range(1, 3);
                repeat (n) begin
                    add_line(1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 19) == 0) begin
                        flush_buffer(1'b0);
                        push_word(1'b1, t_char'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                    end
                end
                flush_buffer(1'b1);
            end
        end

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_pending.size() != 0 || i_valid) @(posedge i_clk);
        while (lines_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (lines_due.size() != 0) begin
            $display("%0d line reports never arrived", lines_due.size());
            mismatches = mismatches + lines_due.size();
        end
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d words left, %0d reports due",
                 words_pending.size(), lines_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
